// File: hdl/ogg_page_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// ogg_page_deframer_unit_macros
// Assertion helpers for the Ogg page deframer.
// Each takes a label, an antecedent, a consequent and a message string.
// ----------------------------------------------------------------------------
`ifndef OGG_PAGE_DEFRAMER_UNIT_MACROS_SVH
`define OGG_PAGE_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Types and constants shared by the Ogg page deframer.
// ----------------------------------------------------------------------------
package opd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_SEGMENTS = 2'd1,
    PH_PAYLOAD  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_LENGTH  = 3'd1,
    K_PAYLOAD = 3'd2,
    K_ERROR   = 3'd3,
    K_END     = 3'd4
  } kind_t;

  // Index of the last header byte (segment count)
  localparam logic [4:0] HDR_LAST  = 5'd26;
  localparam logic [7:0] FULL_LACE = 8'd255;

  localparam logic [4:0] HDR_FLAGS     = 5'd5;
  localparam logic [4:0] HDR_GRAN_LO   = 5'd6;
  localparam logic [4:0] HDR_GRAN_HI   = 5'd13;
  localparam logic [4:0] HDR_SERIAL_LO = 5'd14;
  localparam logic [4:0] HDR_SERIAL_HI = 5'd17;
  localparam logic [4:0] HDR_SEQ_LO    = 5'd18;
  localparam logic [4:0] HDR_SEQ_HI    = 5'd21;
  localparam logic [4:0] HDR_PATTERN_N = 5'd4;

  // Capture pattern "OggS"
  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h4F;
      2'd1:    r = 8'h67;
      2'd2:    r = 8'h67;
      default: r = 8'h53;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ogg_page_deframer_unit.sv
// ----------------------------------------------------------------------------
// ogg_page_deframer_unit
// Ogg page deframer: header fields, packet lengths and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw stream byte per transaction (in_tdata[7:0]).
//   out_* : zero or one result per input byte. out_tuser carries the kind
//           (header, packet length, payload byte, capture error, page end),
//           out_tlast marks the result that closes the page, out_tdata the
//           payload byte, packet length and header fields (zero elsewhere).
//   Output: results are registered; a result appears on out_* in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while not stalled; the whole per-byte
//   update is a single 8/16-bit add and compare ahead of the result register.
//   Bytes that produce nothing (most header bytes, dropped trailing payload)
//   leave the result register untouched.
//   Stall: in_tready follows out_tready while a result is held, so a new
//   byte is taken in the same cycle the held result leaves.
//   Reset (rst_n low, synchronous): parser returns to header byte 0 and the
//   result register is emptied.
// ----------------------------------------------------------------------------
`include "ogg_page_deframer_unit_macros.svh"

module ogg_page_deframer_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [7:0] payload_byte, [23:8] packet_length,
                                   // [31:24] header_flags, [95:32] granule_position,
                                   // [127:96] stream_serial, [159:128] page_sequence
  output logic         out_tlast,  // page_end
  output logic [2:0]   out_tuser   // [2:0] kind
);

  // parser state
  opd_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hcount_r, hcount_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [63:0] gran_r, gran_nxt;
  logic [31:0] serial_r, serial_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [7:0]  seg_left_r, seg_left_nxt;
  logic [15:0] open_len_r, open_len_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] closed_r, closed_nxt;
  logic [15:0] seen_r, seen_nxt;

  // result register
  logic         out_valid_r;
  logic [159:0] out_data_r;
  logic         out_last_r;
  logic [2:0]   out_kind_r;

  // per-byte result
  logic          res_valid;
  opd_pkg::kind_t res_kind;
  logic          res_last;
  logic [7:0]    res_byte;
  logic [15:0]   res_len;
  logic          res_hdr;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] open_sum, total_sum, seen_inc;
  logic [7:0]  seg_dec;
  logic [4:0]  eff_count;
  logic        eff_ok, ok_upd, short_lace;

  assign b          = in_tdata;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign short_lace = (b != opd_pkg::FULL_LACE);
  assign open_sum   = open_len_r + {8'd0, b};
  assign total_sum  = total_r + {8'd0, b};
  assign seg_dec    = seg_left_r - 8'd1;
  assign seen_inc   = seen_r + 16'd1;

  // an unused phase code restarts the header at byte 0
  assign eff_count = (phase_r == opd_pkg::PH_HEADER) ? hcount_r : 5'd0;
  assign eff_ok    = (phase_r == opd_pkg::PH_HEADER) ? ok_r : 1'b1;
  assign ok_upd    = (eff_count < opd_pkg::HDR_PATTERN_N &&
                      b != opd_pkg::capture_byte(eff_count[1:0])) ? 1'b0 : eff_ok;

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    ok_nxt       = ok_r;
    flags_nxt    = flags_r;
    gran_nxt     = gran_r;
    serial_nxt   = serial_r;
    seq_nxt      = seq_r;
    seg_left_nxt = seg_left_r;
    open_len_nxt = open_len_r;
    total_nxt    = total_r;
    closed_nxt   = closed_r;
    seen_nxt     = seen_r;
    if (accept) begin
      unique case (phase_r)
        opd_pkg::PH_SEGMENTS: begin
          total_nxt    = total_sum;
          seg_left_nxt = seg_dec;
          open_len_nxt = short_lace ? 16'd0 : open_sum;
          if (short_lace) begin
            closed_nxt = total_sum;
          end
          if (seg_dec == 8'd0) begin
            if (total_sum == 16'd0) begin
              phase_nxt  = opd_pkg::PH_HEADER;
              hcount_nxt = 5'd0;
              ok_nxt     = 1'b1;
            end else begin
              phase_nxt = opd_pkg::PH_PAYLOAD;
              seen_nxt  = 16'd0;
            end
          end
        end
        opd_pkg::PH_PAYLOAD: begin
          seen_nxt = seen_inc;
          if (seen_inc >= total_r) begin
            phase_nxt  = opd_pkg::PH_HEADER;
            hcount_nxt = 5'd0;
            ok_nxt     = 1'b1;
          end
        end
        default: begin
          if (eff_count == opd_pkg::HDR_FLAGS) begin
            flags_nxt = b;
          end
          if (eff_count >= opd_pkg::HDR_GRAN_LO && eff_count <= opd_pkg::HDR_GRAN_HI) begin
            gran_nxt = {b, gran_r[63:8]};
          end
          if (eff_count >= opd_pkg::HDR_SERIAL_LO &&
              eff_count <= opd_pkg::HDR_SERIAL_HI) begin
            serial_nxt = {b, serial_r[31:8]};
          end
          if (eff_count >= opd_pkg::HDR_SEQ_LO && eff_count <= opd_pkg::HDR_SEQ_HI) begin
            seq_nxt = {b, seq_r[31:8]};
          end
          phase_nxt = opd_pkg::PH_HEADER;
          if (eff_count < opd_pkg::HDR_LAST) begin
            hcount_nxt = eff_count + 5'd1;
            ok_nxt     = ok_upd;
          end else begin
            hcount_nxt = 5'd0;
            ok_nxt     = 1'b1;
            if (ok_upd) begin
              seg_left_nxt = b;
              open_len_nxt = 16'd0;
              total_nxt    = 16'd0;
              closed_nxt   = 16'd0;
              seen_nxt     = 16'd0;
              if (b != 8'd0) begin
                phase_nxt = opd_pkg::PH_SEGMENTS;
              end
            end
          end
        end
      endcase
    end
  end

  // result for the byte on the input
  always_comb begin
    res_valid = 1'b0;
    res_kind  = opd_pkg::K_HEADER;
    res_last  = 1'b0;
    res_byte  = 8'd0;
    res_len   = 16'd0;
    res_hdr   = 1'b0;
    unique case (phase_r)
      opd_pkg::PH_SEGMENTS: begin
        res_valid = short_lace;
        res_kind  = opd_pkg::K_LENGTH;
        res_len   = open_sum;
        res_last  = (seg_dec == 8'd0) && (total_sum == 16'd0);
      end
      opd_pkg::PH_PAYLOAD: begin
        res_last = (seen_inc >= total_r);
        if (seen_r < closed_r) begin
          res_valid = 1'b1;
          res_kind  = opd_pkg::K_PAYLOAD;
          res_byte  = b;
        end else begin
          res_valid = res_last;
          res_kind  = opd_pkg::K_END;
        end
      end
      default: begin
        res_valid = (eff_count == opd_pkg::HDR_LAST);
        if (ok_upd) begin
          res_kind = opd_pkg::K_HEADER;
          res_hdr  = 1'b1;
          res_last = (b == 8'd0);
        end else begin
          res_kind = opd_pkg::K_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= opd_pkg::PH_HEADER;
      hcount_r    <= 5'd0;
      ok_r        <= 1'b1;
      seg_left_r  <= 8'd0;
      open_len_r  <= 16'd0;
      total_r     <= 16'd0;
      closed_r    <= 16'd0;
      seen_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hcount_r   <= hcount_nxt;
      ok_r       <= ok_nxt;
      seg_left_r <= seg_left_nxt;
      open_len_r <= open_len_nxt;
      total_r    <= total_nxt;
      closed_r   <= closed_nxt;
      seen_r     <= seen_nxt;
      if (in_tready) begin
        out_valid_r <= accept && res_valid;
      end
    end
  end

  // header holds are fully rewritten before each header result
  always_ff @(posedge clk) begin
    flags_r  <= flags_nxt;
    gran_r   <= gran_nxt;
    serial_r <= serial_nxt;
    seq_r    <= seq_nxt;
    if (accept && res_valid) begin
      out_kind_r <= res_kind;
      out_last_r <= res_last;
      out_data_r <= res_hdr ? {seq_r, serial_r, gran_r, flags_r, res_len, res_byte}
                            : {136'd0, res_len, res_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  `OPD_ASSERT_NOW(a_err_not_last,
    out_valid_r && out_kind_r == opd_pkg::K_ERROR, !out_last_r,
    "capture error result marked as page end")
  `OPD_ASSERT_NOW(a_end_is_last,
    out_valid_r && out_kind_r == opd_pkg::K_END, out_last_r,
    "page end result without tlast")
  `OPD_ASSERT_NOW(a_payload_nonempty,
    phase_r == opd_pkg::PH_PAYLOAD, total_r != 16'd0,
    "payload phase with empty page")
  `OPD_ASSERT_NOW(a_segments_left,
    phase_r == opd_pkg::PH_SEGMENTS, seg_left_r != 8'd0,
    "segment phase with no segments left")
  `OPD_ASSERT_NEXT(a_header_result,
    accept && phase_r == opd_pkg::PH_HEADER && hcount_r == opd_pkg::HDR_LAST,
    out_valid_r,
    "last header byte gave no result")

endmodule
